/* hw/rtl/uala_pkg.sv */
// Shared types and codes for the unsorted word table.
package uala_pkg;

    localparam logic [2:0] MODE_PUT          = 3'd0;
    localparam logic [2:0] MODE_FIND         = 3'd1;
    localparam logic [2:0] MODE_DELETE       = 3'd2;
    localparam logic [2:0] MODE_NEXT         = 3'd3;
    localparam logic [2:0] MODE_RESET_CURSOR = 3'd4;
    localparam logic [2:0] MODE_CLEAR        = 3'd5;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_END       = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE,
        ST_REPLY
    } state_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] item_value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_value;
        logic [6:0]  entry_count;
        logic        is_full;
    } rsp_t;

endpackage

/* hw/rtl/uala_cell.sv */
// One storage cell of the entry ring: loads a word or takes its neighbour's word.
module uala_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  shift,
    input  logic                  load,
    input  logic [DATA_WIDTH-1:0] din,
    input  logic [DATA_WIDTH-1:0] wval,
    output logic [DATA_WIDTH-1:0] q
);

    logic [DATA_WIDTH-1:0] word_reg;
    logic [DATA_WIDTH-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (load)
        begin
            word_next = wval;
        end
        else if (shift)
        begin
            word_next = din;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign q = word_reg;

endmodule

/* hw/rtl/unsorted_array_list_table.sv */
// Unsorted word table built as a rotating ring of storage cells.
//
// Requests arrive on req (req_valid / req_stall), one result per request
// leaves on rsp (rsp_valid / rsp_stall). An item is taken when valid is high
// and stall is low. One request is worked on at a time; req_stall is high
// from acceptance until the result has moved into the output register.
//
// Put, reset cursor, clear, unused codes and a next at end of list need no
// pass over the ring and go from idle straight to the reply state. Find and
// next rotate the ring once through the head cell in the scan state. Delete
// scans likewise and, only when it finds a match, rotates a second time in
// the move state to drop the last entry into the hole as it passes the head.
// The ring rotates one entry past the head per cycle.
//
// Reset clears count, cursor and handshake state; entry words are not reset.
// A stalled result sits in the output register; a finished request waits for
// that register to free up, and the input stays stalled meanwhile.
module unsorted_array_list_table #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  uala_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output uala_pkg::rsp_t rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    uala_pkg::state_t state_reg, state_next;

    logic [2:0]            op_reg, op_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic [IDX_W-1:0]      step_reg, step_next;
    logic                  hit_reg, hit_next;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic [DATA_WIDTH-1:0] last_reg, last_next;
    logic [DATA_WIDTH-1:0] grab_reg, grab_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      cursor_reg, cursor_next;
    logic [1:0]            status_reg, status_next;
    logic [DATA_WIDTH-1:0] value_reg, value_next;
    uala_pkg::rsp_t        rsp_reg, rsp_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
    logic [DATA_WIDTH-1:0] head;
    logic [DATA_WIDTH-1:0] tail_din;
    logic [DATA_WIDTH-1:0] req_word;
    logic                  ring_shift;
    logic                  put_load;
    logic                  accept;
    logic                  out_free;
    logic                  step_last;
    logic                  in_range;
    logic                  match_now;
    logic                  hit_now;
    logic [IDX_W-1:0]      hit_idx_now;
    logic [DATA_WIDTH-1:0] grab_now;
    logic                  cursor_end;

    assign accept     = req_valid && !req_stall;
    assign req_stall  = (state_reg != uala_pkg::ST_IDLE);
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign req_word   = DATA_WIDTH'(req.item_value);
    assign head       = cell_q[0];
    assign step_last  = (step_reg == LAST_STEP);
    assign in_range   = (CNT_W'(step_reg) < count_reg);
    assign match_now  = in_range && (head == key_reg);
    assign hit_now    = hit_reg || match_now;
    assign hit_idx_now = hit_reg ? hit_idx_reg : step_reg;
    assign grab_now   = (CNT_W'(step_reg) == cursor_reg) ? head : grab_reg;
    assign cursor_end = (cursor_reg >= count_reg);
    assign ring_shift = (state_reg == uala_pkg::ST_SCAN) || (state_reg == uala_pkg::ST_MOVE);
    assign put_load   = accept && (req.mode == uala_pkg::MODE_PUT) && (count_reg < FULL_COUNT);

    // Second pass of a delete drops the last entry into the hole as it wraps.
    assign tail_din = ((state_reg == uala_pkg::ST_MOVE) && (step_reg == hit_idx_reg))
                      ? last_reg : head;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] din;
        if (i == CAPACITY - 1)
        begin : g_tail
            assign din = tail_din;
        end
        else
        begin : g_body
            assign din = cell_q[i+1];
        end

        uala_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .clk  (clk),
            .shift(ring_shift),
            .load (put_load && (count_reg[IDX_W-1:0] == IDX_W'(i))),
            .din  (din),
            .wval (key_next),
            .q    (cell_q[i])
        );
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            uala_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if ((req.mode == uala_pkg::MODE_FIND) || (req.mode == uala_pkg::MODE_DELETE)
                        || ((req.mode == uala_pkg::MODE_NEXT) && !cursor_end))
                    begin
                        state_next = uala_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = uala_pkg::ST_REPLY;
                    end
                end
            end
            uala_pkg::ST_SCAN:
            begin
                if (step_last)
                begin
                    if ((op_reg == uala_pkg::MODE_DELETE) && hit_now)
                    begin
                        state_next = uala_pkg::ST_MOVE;
                    end
                    else
                    begin
                        state_next = uala_pkg::ST_REPLY;
                    end
                end
            end
            uala_pkg::ST_MOVE:
            begin
                if (step_last)
                begin
                    state_next = uala_pkg::ST_REPLY;
                end
            end
            uala_pkg::ST_REPLY:
            begin
                if (out_free)
                begin
                    state_next = uala_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = uala_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        op_next        = op_reg;
        key_next       = key_reg;
        step_next      = step_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        last_next      = last_reg;
        grab_next      = grab_reg;
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        status_next    = status_reg;
        value_next     = value_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            uala_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next     = req.mode;
                    key_next    = req_word;
                    step_next   = '0;
                    hit_next    = 1'b0;
                    status_next = uala_pkg::STATUS_OK;
                    value_next  = '0;
                    case (req.mode)
                        uala_pkg::MODE_PUT:
                        begin
                            if (count_reg < FULL_COUNT)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                status_next = uala_pkg::STATUS_FULL;
                            end
                        end
                        uala_pkg::MODE_NEXT:
                        begin
                            if (cursor_end)
                            begin
                                status_next = uala_pkg::STATUS_END;
                            end
                        end
                        uala_pkg::MODE_RESET_CURSOR:
                        begin
                            cursor_next = '0;
                        end
                        uala_pkg::MODE_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            uala_pkg::ST_SCAN:
            begin
                hit_next     = hit_now;
                hit_idx_next = hit_idx_now;
                grab_next    = grab_now;
                if (CNT_W'(step_reg) == count_reg - 1'b1)
                begin
                    last_next = head;
                end
                step_next = step_last ? '0 : step_reg + 1'b1;
                if (step_last)
                begin
                    case (op_reg)
                        uala_pkg::MODE_NEXT:
                        begin
                            value_next  = grab_now;
                            cursor_next = cursor_reg + 1'b1;
                        end
                        default:
                        begin
                            if (hit_now)
                            begin
                                value_next = key_reg;
                            end
                            else
                            begin
                                status_next = uala_pkg::STATUS_NOT_FOUND;
                            end
                        end
                    endcase
                end
            end
            uala_pkg::ST_MOVE:
            begin
                step_next = step_last ? '0 : step_reg + 1'b1;
                if (step_last)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            uala_pkg::ST_REPLY:
            begin
                if (out_free)
                begin
                    rsp_next.status       = status_reg;
                    rsp_next.result_value = 32'(value_reg);
                    rsp_next.entry_count  = 7'(count_reg);
                    rsp_next.is_full      = (count_reg == FULL_COUNT);
                    rsp_valid_next        = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= uala_pkg::ST_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            step_reg      <= '0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            step_reg      <= step_next;
            hit_reg       <= hit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        hit_idx_reg <= hit_idx_next;
        last_reg    <= last_next;
        grab_reg    <= grab_next;
        status_reg  <= status_next;
        value_reg   <= value_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= FULL_COUNT)
        else $error("read cursor beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == uala_pkg::ST_SCAN) && step_last |=> (state_reg != uala_pkg::ST_SCAN))
        else $error("scan did not end after one revolution");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == uala_pkg::ST_MOVE) |-> hit_reg && (count_reg != '0))
        else $error("move pass without a matching entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        ring_shift |-> (step_reg != '0) || $past(state_reg) != state_reg
                       || (state_reg == uala_pkg::ST_SCAN) || (state_reg == uala_pkg::ST_MOVE))
        else $error("ring rotating outside a pass");

endmodule

/* dv/unsorted_array_list_table_tb.sv */
// Self-checking testbench for the unsorted word table: directed and random requests, scoreboarded.
module unsorted_array_list_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP          = 64;
    localparam int RANDOM_ITEMS = 925;
    localparam int TAIL_ITEMS   = 100;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 2 * CAP + 10;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int POOL_SIZE    = 24;

    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BROWSE} mix_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    uala_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    uala_pkg::rsp_t rsp;

    unsorted_array_list_table #(
        .CAPACITY   (CAP),
        .DATA_WIDTH (32)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow of the table contents
    logic [31:0] words [CAP];
    int          word_count = 0;
    int          cursor     = 0;

    uala_pkg::req_t pending_q [$];
    uala_pkg::rsp_t reply_q [$];
    logic [31:0]    pool [POOL_SIZE];

    int errors        = 0;
    int replies       = 0;
    int total_items   = 0;
    int accepted_items = 0;
    int mode_seen [8] = '{default: 0};
    int full_seen     = 0;
    int miss_seen     = 0;
    int end_seen      = 0;
    int peak_count    = 0;
    int send_rate     = 0;
    int recv_rate     = 0;
    int cycles        = 0;
    logic tail;

    assign tail = (accepted_items >= total_items - TAIL_ITEMS);

    function automatic uala_pkg::rsp_t table_apply(uala_pkg::req_t r);
        uala_pkg::rsp_t o;
        int   hit;
        o = '0;
        o.status = uala_pkg::STATUS_OK;
        hit = -1;
        case (r.mode)
            uala_pkg::MODE_PUT:
            begin
                if (word_count >= CAP)
                    o.status = uala_pkg::STATUS_FULL;
                else
                begin
                    words[word_count] = r.item_value;
                    word_count++;
                end
            end
            uala_pkg::MODE_FIND, uala_pkg::MODE_DELETE:
            begin
                for (int i = 0; i < word_count; i++)
                    if (hit < 0 && words[i] == r.item_value)
                        hit = i;
                if (hit < 0)
                    o.status = uala_pkg::STATUS_NOT_FOUND;
                else
                begin
                    o.result_value = r.item_value;
                    if (r.mode == uala_pkg::MODE_DELETE)
                    begin
                        // last entry fills the hole
                        words[hit] = words[word_count - 1];
                        word_count--;
                    end
                end
            end
            uala_pkg::MODE_NEXT:
            begin
                // cursor may sit past the count after deletes or clear
                if (cursor >= word_count)
                    o.status = uala_pkg::STATUS_END;
                else
                begin
                    o.result_value = words[cursor];
                    cursor++;
                end
            end
            uala_pkg::MODE_RESET_CURSOR: cursor = 0;
            uala_pkg::MODE_CLEAR:        word_count = 0;
            default: ;
        endcase
        o.entry_count = word_count[6:0];
        o.is_full = (word_count == CAP);
        return o;
    endfunction

    function automatic logic [2:0] pick_op(mix_t mix, int roll);
        logic [2:0] spare;
        spare = roll[0] ? MODE_SPARE_A : MODE_SPARE_B;
        case (mix)
            MIX_FILL:
                if (roll < 78)      return uala_pkg::MODE_PUT;
                else if (roll < 85) return uala_pkg::MODE_FIND;
                else if (roll < 90) return uala_pkg::MODE_DELETE;
                else if (roll < 96) return uala_pkg::MODE_NEXT;
                else if (roll < 98) return uala_pkg::MODE_RESET_CURSOR;
                else                return spare;
            MIX_DRAIN:
                if (roll < 12)      return uala_pkg::MODE_PUT;
                else if (roll < 27) return uala_pkg::MODE_FIND;
                else if (roll < 72) return uala_pkg::MODE_DELETE;
                else if (roll < 88) return uala_pkg::MODE_NEXT;
                else if (roll < 95) return uala_pkg::MODE_RESET_CURSOR;
                else if (roll < 97) return uala_pkg::MODE_CLEAR;
                else                return spare;
            default:
                if (roll < 35)      return uala_pkg::MODE_PUT;
                else if (roll < 52) return uala_pkg::MODE_FIND;
                else if (roll < 68) return uala_pkg::MODE_DELETE;
                else if (roll < 86) return uala_pkg::MODE_NEXT;
                else if (roll < 94) return uala_pkg::MODE_RESET_CURSOR;
                else if (roll < 97) return uala_pkg::MODE_CLEAR;
                else                return spare;
        endcase
    endfunction

    // mostly words from a small pool so finds and deletes hit, with duplicates
    function automatic logic [31:0] pick_word();
        if ($urandom_range(99) < 85)
            return pool[$urandom_range(POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic int idle_rate();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 4;
            2:       return 12;
            default: return 30;
        endcase
    endfunction

    task automatic add_item(logic [2:0] mode, logic [31:0] value);
        uala_pkg::req_t r;
        r.mode = mode;
        r.item_value = value;
        pending_q.push_back(r);
    endtask

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("MISMATCH %s at reply %0d: got %0h, expected %0h",
                 what, replies, got, want);
    endtask

    // cycle count, idle rates and the watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles % 256 == 0)
        begin
            send_rate <= idle_rate();
            recv_rate <= idle_rate();
        end
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Timed out after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // request driver
    logic [4:0] send_gap = '0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            send_gap <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                reply_q.push_back(table_apply(req));
                accepted_items <= accepted_items + 1;
                mode_seen[req.mode] <= mode_seen[req.mode] + 1;
            end
            if (!req_valid || !req_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 5'd1;
                    req_valid <= 1'b0;
                end
                else if (!tail && $urandom_range(99) < send_rate)
                begin
                    send_gap <= 5'($urandom_range(18));
                    req_valid <= 1'b0;
                end
                else if (pending_q.size() != 0)
                begin
                    req <= pending_q.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // one long receiver hold-off, counted here, while the sender keeps offering items
    int   hold_left = 0;
    logic hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && accepted_items >= 300)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // reply monitor and receiver stall
    logic [4:0] stall_gap = '0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_gap <= '0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                replies <= replies + 1;
                if (reply_q.size() == 0)
                    flag_mismatch("unexpected reply", rsp.result_value, '0);
                else
                begin
                    uala_pkg::rsp_t want;
                    want = reply_q.pop_front();
                    if (rsp.status != want.status)
                        flag_mismatch("status", rsp.status, want.status);
                    if (rsp.result_value != want.result_value)
                        flag_mismatch("result_value", rsp.result_value, want.result_value);
                    if (rsp.entry_count != want.entry_count)
                        flag_mismatch("entry_count", rsp.entry_count, want.entry_count);
                    if (rsp.is_full != want.is_full)
                        flag_mismatch("is_full", rsp.is_full, want.is_full);
                end
                case (rsp.status)
                    uala_pkg::STATUS_FULL:      full_seen <= full_seen + 1;
                    uala_pkg::STATUS_NOT_FOUND: miss_seen <= miss_seen + 1;
                    uala_pkg::STATUS_END:       end_seen <= end_seen + 1;
                    default: ;
                endcase
                if (rsp.entry_count > peak_count)
                    peak_count <= rsp.entry_count;
            end

            if (hold_left != 0)
                rsp_stall <= 1'b1;
            else if (stall_gap != 0)
            begin
                stall_gap <= stall_gap - 5'd1;
                rsp_stall <= 1'b1;
            end
            else if (!tail && $urandom_range(99) < recv_rate)
            begin
                stall_gap <= 5'($urandom_range(18));
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    initial
    begin
        mix_t mix;
        int   span;
        int   made;
        logic first;

        for (int i = 0; i < POOL_SIZE; i++)
            pool[i] = $urandom;
        pool[0] = 32'h0000_0000;
        pool[1] = 32'hFFFF_FFFF;

        // directed opening: empty table, extremes, duplicates, end of list, spare codes
        add_item(uala_pkg::MODE_NEXT,         32'h0);
        add_item(uala_pkg::MODE_FIND,         32'h0);
        add_item(uala_pkg::MODE_DELETE,       32'h5);
        add_item(uala_pkg::MODE_PUT,          32'h0000_0000);
        add_item(uala_pkg::MODE_PUT,          32'hFFFF_FFFF);
        add_item(uala_pkg::MODE_PUT,          32'hA5A5_A5A5);
        add_item(uala_pkg::MODE_PUT,          32'h0000_0000);
        add_item(uala_pkg::MODE_PUT,          32'h5A5A_5A5A);
        add_item(uala_pkg::MODE_FIND,         32'hFFFF_FFFF);
        add_item(uala_pkg::MODE_FIND,         32'h1234_5678);
        add_item(uala_pkg::MODE_DELETE,       32'h0000_0000);
        add_item(uala_pkg::MODE_FIND,         32'h0000_0000);
        add_item(uala_pkg::MODE_NEXT,         32'h0);
        add_item(uala_pkg::MODE_NEXT,         32'h0);
        add_item(uala_pkg::MODE_NEXT,         32'h0);
        add_item(uala_pkg::MODE_DELETE,       32'hA5A5_A5A5);
        add_item(uala_pkg::MODE_NEXT,         32'hFFFF_FFFF);
        add_item(uala_pkg::MODE_RESET_CURSOR, 32'hFFFF_FFFF);
        add_item(uala_pkg::MODE_NEXT,         32'h0);
        add_item(MODE_SPARE_A,                32'h8000_0001);
        add_item(MODE_SPARE_B,                32'hFFFF_FFFF);
        add_item(uala_pkg::MODE_CLEAR,        32'h0);
        add_item(uala_pkg::MODE_NEXT,         32'h0);
        add_item(uala_pkg::MODE_PUT,          32'h0000_0001);
        add_item(uala_pkg::MODE_RESET_CURSOR, 32'h0);

        // random blocks; the first one fills the table past capacity
        made = 0;
        first = 1'b1;
        while (made < RANDOM_ITEMS)
        begin
            mix = first ? MIX_FILL : mix_t'($urandom_range(2));
            span = first ? 110 : $urandom_range(120, 40);
            first = 1'b0;
            repeat (span)
            begin
                if (made < RANDOM_ITEMS)
                begin
                    add_item(pick_op(mix, $urandom_range(99)), pick_word());
                    made++;
                end
            end
        end
        total_items = pending_q.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || req_valid || reply_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        while (reply_q.size() != 0)
        begin
            void'(reply_q.pop_front());
            flag_mismatch("missing reply", '0, '1);
        end

        $display("Covered %0d requests: %0d put, %0d find, %0d delete, %0d next,",
                 accepted_items, mode_seen[uala_pkg::MODE_PUT], mode_seen[uala_pkg::MODE_FIND],
                 mode_seen[uala_pkg::MODE_DELETE], mode_seen[uala_pkg::MODE_NEXT]);
        $display("  %0d cursor reset, %0d clear, %0d spare; replies %0d: %0d full,",
                 mode_seen[uala_pkg::MODE_RESET_CURSOR], mode_seen[uala_pkg::MODE_CLEAR],
                 mode_seen[MODE_SPARE_A] + mode_seen[MODE_SPARE_B], replies, full_seen);
        $display("  %0d not found, %0d end of list, peak count %0d",
                 miss_seen, end_seen, peak_count);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/uala_pkg.sv
hw/rtl/uala_cell.sv
hw/rtl/unsorted_array_list_table.sv
dv/unsorted_array_list_table_tb.sv
